[rtl/rect_reading_order_sorter_unit_assert.svh]
// Assertion macros shared by the rectangle sorter RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef RECT_READING_ORDER_SORTER_UNIT_ASSERT_SVH
`define RECT_READING_ORDER_SORTER_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define RROS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// The consequent must hold whenever the antecedent holds.
`define RROS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/rros_pkg.sv]
// Package of the rectangle reading-order sorter: constants, entry and control types and key function.
// No dependencies.
package rros_pkg;
    localparam int MAX_RECTS  = 64;
    localparam int COORD_BITS = 12;
    localparam int ROW_W      = 6;
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);
    localparam int KEY_W      = ROW_W + COORD_BITS;
    localparam logic [ROW_W-1:0]      ROW_MAX       = 6'd63;
    localparam logic [COORD_BITS-1:0] ROW_GAP_RESET = 12'd35;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0]      row;
        logic [COORD_BITS-1:0] h;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } t_ent;

    typedef struct packed {
        logic ins;
        logic pop;
        logic by_y;
    } t_ctl;

    function automatic logic [KEY_W-1:0] f_key(t_ent e, logic by_y);
        return by_y ? {{ROW_W{1'b0}}, e.y} : {e.row, e.x};
    endfunction
endpackage

[rtl/rros_cell.sv]
// One cell of the sorting chain: holds one entry and its valid bit.
// Depends on rros_pkg.
module rros_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rros_pkg::t_ctl i_ctl,
    input  rros_pkg::t_ent i_new,
    input  rros_pkg::t_ent i_left_ent,
    input  logic          i_left_v,
    input  logic          i_left_ins,
    input  rros_pkg::t_ent i_right_ent,
    input  logic          i_right_v,
    output rros_pkg::t_ent o_ent,
    output logic          o_v,
    output logic          o_ins
);
    import rros_pkg::*;

    t_ent r_ent, n_ent;
    logic r_v, n_v;

    assign o_ins = !r_v || (f_key(r_ent, i_ctl.by_y) > f_key(i_new, i_ctl.by_y));
    assign o_ent = r_ent;
    assign o_v   = r_v;

    always_comb begin
        n_ent = r_ent;
        n_v   = r_v;
        if (i_ctl.pop) begin
            n_ent = i_right_ent;
            n_v   = i_right_v;
        end else if (i_ctl.ins && o_ins) begin
            if (i_left_ins) begin
                n_ent = i_left_ent;
                n_v   = i_left_v;
            end else begin
                n_ent = i_new;
                n_v   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end
endmodule

[rtl/rros_chain.sv]
// Row of sorting cells kept in ascending key order, with insert and pop-head.
// Depends on rros_pkg, rros_cell and the assertion header.
`include "rect_reading_order_sorter_unit_assert.svh"
module rros_chain (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rros_pkg::t_ctl i_ctl,
    input  rros_pkg::t_ent i_new,
    output rros_pkg::t_ent o_head,
    output logic          o_head_v,
    output logic          o_next_v
);
    import rros_pkg::*;

    t_ent                 w_ent [MAX_RECTS];
    logic [MAX_RECTS-1:0] w_v;
    logic [MAX_RECTS-1:0] w_ins;
    logic                 w_contig;

    for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cell
        t_ent w_l_ent, w_r_ent;
        logic w_l_v, w_l_ins, w_r_v;
        if (g == 0) begin : g_first
            assign w_l_ent = i_new;
            assign w_l_v   = 1'b0;
            assign w_l_ins = 1'b0;
        end else begin : g_mid
            assign w_l_ent = w_ent[g-1];
            assign w_l_v   = w_v[g-1];
            assign w_l_ins = w_ins[g-1];
        end
        if (g == MAX_RECTS - 1) begin : g_last
            assign w_r_ent = i_new;
            assign w_r_v   = 1'b0;
        end else begin : g_inner
            assign w_r_ent = w_ent[g+1];
            assign w_r_v   = w_v[g+1];
        end
        rros_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_new       (i_new),
            .i_left_ent  (w_l_ent),
            .i_left_v    (w_l_v),
            .i_left_ins  (w_l_ins),
            .i_right_ent (w_r_ent),
            .i_right_v   (w_r_v),
            .o_ent       (w_ent[g]),
            .o_v         (w_v[g]),
            .o_ins       (w_ins[g])
        );
    end

    assign o_head   = w_ent[0];
    assign o_head_v = w_v[0];
    assign o_next_v = w_v[1];
    assign w_contig = (((w_v + MAX_RECTS'(1)) & w_v) == '0);

    `RROS_ASSERT_ALWAYS(a_chain_contig, w_contig, "chain valid bits not contiguous")
    `RROS_ASSERT_IMPL(a_no_ins_full, i_ctl.ins, !w_v[MAX_RECTS-1], "insert into full chain")
    `RROS_ASSERT_IMPL(a_pop_excl, i_ctl.pop, !i_ctl.ins, "pop and insert together")
endmodule

[rtl/rect_reading_order_sorter_unit.sv]
// Top level of the rectangle reading-order sorter: control, row split and output register.
// Depends on rros_pkg, rros_chain and the assertion header.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: x, y, w, h; tlast: last of set
//  m_axis    out        tdata: x, y, w, h, row, overflow; tlast: last of output
//  cfg       in         row_gap
//
// Loading inserts rectangles into a y-ordered cell chain.
// The row split moves one entry per cycle into a second chain ordered by row and x.
// Emission pops one entry per cycle while the output register is free. Reset is
// synchronous and active low and empties both chains. The input is stalled from the
// last transaction of a set until all of its results have been taken.
`include "rect_reading_order_sorter_unit_assert.svh"
module rect_reading_order_sorter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // rect_x, rect_y, rect_w, rect_h
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // out_x, out_y, out_w, out_h, row_number, overflow
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);
    import rros_pkg::*;

    logic [1:0]            r_st, n_st;
    logic [CNT_W-1:0]      r_count;
    logic                  r_drop;
    logic [COORD_BITS-1:0] r_gap;
    logic [COORD_BITS-1:0] r_prev_y;
    logic [ROW_W-1:0]      r_row, n_row;
    logic                  r_first;
    t_ent                  r_out;
    logic                  r_ovf, r_olast, r_ovalid;

    t_ctl                  w_ctl_a, w_ctl_b;
    t_ent                  w_new_a, w_head_a, w_new_b, w_head_b;
    logic                  w_ahv, w_anv, w_bhv, w_bnv;
    logic                  w_acc, w_full, w_free;
    logic [COORD_BITS-1:0] w_dy;

    assign s_axis_tready = (r_st == ST_LOAD);
    assign o_cfg_ready   = 1'b1;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_full = (r_count == CNT_W'(MAX_RECTS));
    assign w_free = !r_ovalid || m_axis_tready;

    always_comb begin
        w_new_a     = '0;
        w_new_a.x   = s_axis_tdata[11:0];
        w_new_a.y   = s_axis_tdata[23:12];
        w_new_a.w   = s_axis_tdata[35:24];
        w_new_a.h   = s_axis_tdata[47:36];
        w_ctl_a.ins  = w_acc && !w_full;
        w_ctl_a.pop  = (r_st == ST_SORT) && w_ahv;
        w_ctl_a.by_y = 1'b1;
    end

    assign w_dy = w_head_a.y - r_prev_y;
    always_comb begin
        n_row = r_row;
        if (r_first) begin
            n_row = '0;
        end else if (w_dy > r_gap && r_row < ROW_MAX) begin
            n_row = r_row + 1'b1;
        end
        w_new_b      = w_head_a;
        w_new_b.row  = n_row;
        w_ctl_b.ins  = w_ctl_a.pop;
        w_ctl_b.pop  = (r_st == ST_EMIT) && w_bhv && w_free;
        w_ctl_b.by_y = 1'b0;
    end

    rros_chain u_chain_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_a),
        .i_new    (w_new_a),
        .o_head   (w_head_a),
        .o_head_v (w_ahv),
        .o_next_v (w_anv)
    );

    rros_chain u_chain_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_b),
        .i_new    (w_new_b),
        .o_head   (w_head_b),
        .o_head_v (w_bhv),
        .o_next_v (w_bnv)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_LOAD: if (w_acc && s_axis_tlast) n_st = ST_SORT;
            ST_SORT: if (!w_ahv) n_st = ST_EMIT;
            ST_EMIT: if (!w_bhv && w_free) n_st = ST_LOAD;
            default: n_st = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl_a.pop) begin
            r_prev_y <= w_head_a.y;
        end
        if (w_ctl_b.pop) begin
            r_out   <= w_head_b;
            r_olast <= !w_bnv;
            r_ovf   <= r_drop;
        end
        if (!i_rst_n) begin
            r_st     <= ST_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_gap    <= ROW_GAP_RESET;
            r_row    <= '0;
            r_first  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) begin
                r_gap <= i_cfg_data;
            end
            if (w_ctl_a.ins) begin
                r_count <= r_count + 1'b1;
            end
            if (w_acc && w_full) begin
                r_drop <= 1'b1;
            end
            if (w_acc && s_axis_tlast) begin
                r_first <= 1'b1;
            end else if (w_ctl_a.pop) begin
                r_first <= 1'b0;
                r_row   <= n_row;
            end
            if (w_ctl_b.pop) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_st == ST_EMIT && n_st == ST_LOAD) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_ovf, r_out.row, r_out.h, r_out.w, r_out.y, r_out.x};
    assign m_axis_tlast  = r_olast;

    `RROS_ASSERT_ALWAYS(a_count_max, r_count <= CNT_W'(MAX_RECTS), "count above capacity")
    `RROS_ASSERT_IMPL(a_out_emit, m_axis_tvalid, r_st == ST_EMIT, "output valid outside emit")
    `RROS_ASSERT_IMPL(a_sort_nob, r_st == ST_LOAD, !w_bhv, "row chain busy while loading")
    `RROS_ASSERT_IMPL(a_y_head, w_anv, w_ahv, "second entry valid without a head entry")
endmodule

[bench/tb_rect_reading_order_sorter_unit.sv]
// Self-checking testbench of the rectangle reading-order sorter: random rectangle sets,
// row gap settings and handshake stalls, checked against a behavioural sort model.
// Depends on rros_pkg and the rect_reading_order_sorter_unit RTL.
`timescale 1ns / 100ps

class reading_order_board;
    logic [11:0] box_x[$];
    logic [11:0] box_y[$];
    logic [11:0] box_w[$];
    logic [11:0] box_h[$];
    bit          dropped;
    logic [11:0] gap;
    logic [55:0] pending_data[$];
    bit          pending_last[$];
    int          errors;
    int          sets_sorted;
    int          results_seen;

    function new();
        gap = rros_pkg::ROW_GAP_RESET;
    endfunction

    // Stable insertion sort of ord[lo..hi) by y or by x.
    function void sort_span(ref int ord[64], input int lo, input int hi, input bit by_y);
        int i, j, cur;
        logic [11:0] k, pk;
        for (i = lo + 1; i < hi; i++) begin
            cur = ord[i];
            k = by_y ? box_y[cur] : box_x[cur];
            j = i;
            while (j > lo) begin
                pk = by_y ? box_y[ord[j-1]] : box_x[ord[j-1]];
                if (pk <= k) break;
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = cur;
        end
    endfunction

    function void note_rect(logic [47:0] d, bit lst);
        int ord[64];
        int rowv[64];
        int n, i, start, r;
        if (box_x.size() < rros_pkg::MAX_RECTS) begin
            box_x.insert(box_x.size(), d[11:0]);
            box_y.insert(box_y.size(), d[23:12]);
            box_w.insert(box_w.size(), d[35:24]);
            box_h.insert(box_h.size(), d[47:36]);
        end else begin
            dropped = 1;
        end
        if (!lst) return;
        n = box_x.size();
        for (i = 0; i < n; i++) ord[i] = i;
        sort_span(ord, 0, n, 1);
        start = 0;
        r = 0;
        rowv[0] = 0;
        for (i = 1; i < n; i++) begin
            if (box_y[ord[i]] - box_y[ord[i-1]] > gap) begin
                sort_span(ord, start, i, 0);
                start = i;
                if (r < 63) r++;
            end
            rowv[i] = r;
        end
        if (n > 0) sort_span(ord, start, n, 0);
        for (i = 0; i < n; i++) begin
            pending_data.insert(pending_data.size(),
                                {1'b0, dropped, 6'(rowv[i]), box_h[ord[i]], box_w[ord[i]],
                                 box_y[ord[i]], box_x[ord[i]]});
            pending_last.insert(pending_last.size(), i == n - 1);
        end
        box_x.delete(); box_y.delete(); box_w.delete(); box_h.delete();
        dropped = 0;
        sets_sorted++;
    endfunction

    function void check_result(logic [55:0] d, logic lst);
        logic [55:0] ed;
        bit el;
        results_seen++;
        if (pending_data.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result %h last %b", d, lst);
            return;
        end
        ed = pending_data.pop_front();
        el = pending_last.pop_front();
        if (ed !== d || el !== lst) begin
            errors++;
            if (errors <= 10) begin
                $display("Mismatch: expected x %0d y %0d w %0d h %0d row %0d ovf %b last %b,",
                         ed[11:0], ed[23:12], ed[35:24], ed[47:36], ed[53:48], ed[54], el);
                $display("          got x %0d y %0d w %0d h %0d row %0d ovf %b last %b",
                         d[11:0], d[23:12], d[35:24], d[47:36], d[53:48], d[54], lst);
            end
        end
    endfunction
endclass

module tb_rect_reading_order_sorter_unit;
    localparam int WATCHDOG = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [11:0] i_cfg_data = '0;

    reading_order_board board = new();
    int  idle_cycles;
    int  rects_sent;
    int  stall_mode;

    rect_reading_order_sorter_unit dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_rect(s_axis_tdata, s_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Watchdog expired");
            $display("[rect_reading_order_sorter_unit] ERROR");
            $finish;
        end
    end

    // Receiver stall pattern: phases of always ready and of random stalls of varying density.
    always @(posedge i_clk) begin
        case (stall_mode)
            0: m_axis_tready <= 1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= ($urandom_range(0, 1) == 1);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    end

    task automatic send_rect(logic [11:0] x, logic [11:0] y, logic [11:0] w, logic [11:0] h,
                             bit lst);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {h, w, y, x};
        s_axis_tlast <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rects_sent++;
    endtask

    task automatic gap_cycles(int n);
        if (n > 0) begin
            s_axis_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (board.pending_data.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_gap(logic [11:0] v);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        board.gap = v;
    endtask

    // One set of n rectangles, y clustered into bands so that rows form.
    task automatic random_set(int n, int spread);
        int i, burst;
        logic [11:0] band;
        burst = $urandom_range(1, 8);
        band = 12'($urandom);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) band = 12'($urandom);
            send_rect(12'($urandom), 12'(band + $urandom_range(0, spread)), 12'($urandom),
                      12'($urandom), i == n - 1);
            if (--burst == 0) begin
                gap_cycles($urandom_range(0, 4));
                burst = $urandom_range(1, 8);
            end
        end
        s_axis_tvalid <= 0;
    endtask

    initial begin
        int i;
        stall_mode = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, ties, a single rectangle and the reset row gap.
        send_rect(12'd0, 12'd0, 12'd0, 12'd0, 1);
        send_rect(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 0);
        send_rect(12'd5, 12'd35, 12'd1, 12'd2, 0);
        send_rect(12'd5, 12'd0, 12'd3, 12'd4, 0);
        send_rect(12'd2, 12'd36, 12'd5, 12'd6, 0);
        send_rect(12'd5, 12'd71, 12'd7, 12'd8, 0);
        send_rect(12'd0, 12'hFFF, 12'h555, 12'hAAA, 1);
        drain();
        write_gap(12'd0);
        for (i = 0; i < 6; i++) send_rect(12'(i % 2), 12'(i / 2), 12'hAAA, 12'h555, i == 5);
        drain();
        // Capacity overflow, with the marked last rectangle dropped too.
        write_gap(12'hFFF);
        for (i = 0; i < 66; i++)
            send_rect(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), i == 65);
        drain();
        // A full set with a new row at every rectangle reaches the top row number.
        write_gap(12'd0);
        for (i = 0; i < 64; i++)
            send_rect(12'($urandom), 12'(i * 3), 12'($urandom), 12'($urandom), i == 63);
        drain();

        for (i = 0; rects_sent < 440; i++) begin
            if (i % 6 == 0) begin
                drain();
                case ($urandom_range(0, 3))
                    0: write_gap(12'd0);
                    1: write_gap(12'hFFF);
                    default: write_gap(12'($urandom_range(0, 80)));
                endcase
            end
            random_set($urandom_range(0, 9) == 0 ? $urandom_range(30, 68)
                                                 : $urandom_range(1, 10),
                       $urandom_range(0, 120));
            if (i == 3) drain();
        end
        drain();
        $display("Sent %0d rectangles in %0d sets; %0d results checked.",
                 rects_sent, board.sets_sorted, board.results_seen);
        if (board.errors == 0 && board.pending_data.size() == 0)
            $display("[rect_reading_order_sorter_unit] OK");
        else
            $display("[rect_reading_order_sorter_unit] ERROR");
        $finish;
    end
endmodule
